### design/rwl_pkg.sv
// Package for the reader-writer lock arbiter.
// Holds the request kinds, event codes, field widths and controller/datapath structs.
// No dependencies.
`default_nettype none

package rwl_pkg;

  localparam int REQUESTERS_DEF = 16;

  localparam int KIND_W  = 2;
  localparam int ID_W    = 4;
  localparam int EVENT_W = 3;

  localparam logic [KIND_W-1:0] KIND_ACQ_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACQ_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REL_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REL_WRITE = 2'd3;

  localparam logic [EVENT_W-1:0] EV_QUEUED      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_HELD        = 3'd1;
  localparam logic [EVENT_W-1:0] EV_RELEASED    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_READ_GRANT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_WRITE_GRANT = 3'd4;
  localparam logic [EVENT_W-1:0] EV_ERROR       = 3'd5;

  typedef struct packed {
    logic load_req;
    logic apply_req;
    logic read_heads;
    logic apply_grant;
    logic emit;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic grant_ok;
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

### design/rwl_req_if.sv
// Request channel of the reader-writer lock arbiter: kind and requester id.
// Depends on rwl_pkg for field widths.
`default_nettype none

interface rwl_req_if;
  logic                       valid;
  logic                       ready;
  logic [rwl_pkg::KIND_W-1:0] kind;
  logic [rwl_pkg::ID_W-1:0]   requester;

  modport source (output valid, output kind, output requester, input ready);
  modport sink (input valid, input kind, input requester, output ready);
endinterface

`default_nettype wire

### design/rwl_res_if.sv
// Result channel of the reader-writer lock arbiter: event code, requester, last flag.
// Depends on rwl_pkg for field widths.
`default_nettype none

interface rwl_res_if;
  logic                        valid;
  logic                        ready;
  logic [rwl_pkg::EVENT_W-1:0] event_res;
  logic [rwl_pkg::ID_W-1:0]    who;
  logic                        last;

  modport source (output valid, output event_res, output who, output last, input ready);
  modport sink (input valid, input event_res, input who, input last, output ready);
endinterface

`default_nettype wire

### design/reader_writer_lock_arbiter_top.sv
// Reader-writer lock arbiter with FIFO ordering and read-to-write upgrade.
// Request channel req (kind, requester) in, result channel res (event_res, who, last) out.
// Each request yields one answer word (queued, already held, released or error) followed
// by zero or more grant words for queued requesters, in grant order; last marks the
// final word for that request. Upgrade requests are served ahead of the wait queue.
// Timing: a request is taken in the idle cycle and applied in the next; each grant check
// then reads the queue heads and evaluates them. A stalled receiver holds res in its
// output register; the walk waits in its evaluate step until the word is taken, and
// req is not accepted until the request's last word is in the output register.
// Reset (synchronous, active high) clears the reader set, writer, queues and output
// valid; queue storage is not cleared.
`default_nettype none

module reader_writer_lock_arbiter_top #(
  parameter int REQUESTERS = rwl_pkg::REQUESTERS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rwl_req_if.sink   req,
  rwl_res_if.source res
);

  rwl_pkg::cmd_t    cmd;
  rwl_pkg::status_t status;
  logic             ready;

  rwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .status    (status),
    .cmd       (cmd)
  );

  rwl_dp #(
    .REQUESTERS (REQUESTERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (req.kind),
    .requester (req.requester),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .res_event (res.event_res),
    .res_who   (res.who),
    .res_last  (res.last)
  );

  assign req.ready = ready;

endmodule

`default_nettype wire

### design/rwl_ctrl.sv
// Sequencing controller of the reader-writer lock arbiter.
// Depends on rwl_pkg (cmd_t, status_t); drives rwl_dp through commands.
`default_nettype none

module rwl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire rwl_pkg::status_t status,
  output rwl_pkg::cmd_t         cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REQ  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_REQ;
        end
      end
      S_REQ: begin
        cmd.apply_req = 1'b1;
        state_next    = S_RD;
      end
      S_RD: begin
        cmd.read_heads = 1'b1;
        state_next     = S_EVAL;
      end
      S_EVAL: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.grant_ok) begin
            cmd.apply_grant = 1'b1;
            state_next      = S_RD;
          end else begin
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### design/rwl_dp.sv
// Datapath of the reader-writer lock arbiter: lock state, wait and upgrade queues,
// pending result and output register. Depends on rwl_pkg; commanded by rwl_ctrl.
`default_nettype none

module rwl_dp #(
  parameter int REQUESTERS = rwl_pkg::REQUESTERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rwl_pkg::cmd_t               cmd,
  output rwl_pkg::status_t                 status,
  input  wire logic [rwl_pkg::KIND_W-1:0]  kind,
  input  wire logic [rwl_pkg::ID_W-1:0]    requester,
  input  wire logic                        res_ready,
  output logic                             res_valid,
  output logic [rwl_pkg::EVENT_W-1:0]      res_event,
  output logic [rwl_pkg::ID_W-1:0]         res_who,
  output logic                             res_last
);

  localparam int PW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int CW = $clog2(REQUESTERS + 1);
  localparam int SW = CW + 1;
  localparam int EW = rwl_pkg::ID_W + 1;

  typedef logic [REQUESTERS-1:0] mask_t;

  // latched request
  logic [rwl_pkg::KIND_W-1:0] kind_q;
  logic [rwl_pkg::ID_W-1:0]   req_q;

  // lock state
  mask_t                    reader_set, reader_set_next;
  mask_t                    was_reading, was_reading_next;
  mask_t                    waiting_mask, waiting_mask_next;
  logic                     writer_active, writer_active_next;
  logic [rwl_pkg::ID_W-1:0] writer_id, writer_id_next;

  // queues
  logic [EW-1:0]            wait_mem [REQUESTERS];
  logic [rwl_pkg::ID_W-1:0] upg_mem [REQUESTERS];
  logic [PW-1:0]            wq_head, wq_head_next, uq_head, uq_head_next;
  logic [CW-1:0]            wq_cnt, wq_cnt_next, uq_cnt, uq_cnt_next;
  logic [PW-1:0]            wq_tail, uq_tail;
  logic [SW-1:0]            wq_sum, uq_sum;
  logic [EW-1:0]            wq_data;
  logic [rwl_pkg::ID_W-1:0] uq_data;

  // pending and output results
  logic [rwl_pkg::EVENT_W-1:0] pend_ev;
  logic [rwl_pkg::ID_W-1:0]    pend_who;

  // request decode
  mask_t                       req_bit;
  logic                        in_range, waiting, is_reader, is_writer, wq_full, uq_full;
  logic                        push_wait, push_upg, clr_reader, release_w;
  logic [rwl_pkg::EVENT_W-1:0] req_ev;

  // grant decode
  logic                     g_any, g_from_upg, g_write, g_ok;
  logic [rwl_pkg::ID_W-1:0] g_id;
  mask_t                    g_bit;

  always_comb begin
    wq_sum = SW'(wq_head) + SW'(wq_cnt);
    if (wq_sum >= SW'(REQUESTERS)) begin
      wq_sum = wq_sum - SW'(REQUESTERS);
    end
    uq_sum = SW'(uq_head) + SW'(uq_cnt);
    if (uq_sum >= SW'(REQUESTERS)) begin
      uq_sum = uq_sum - SW'(REQUESTERS);
    end
  end
  assign wq_tail = wq_sum[PW-1:0];
  assign uq_tail = uq_sum[PW-1:0];
  assign wq_full = (wq_cnt == CW'(REQUESTERS));
  assign uq_full = (uq_cnt == CW'(REQUESTERS));

  assign in_range  = (32'(req_q) < 32'(REQUESTERS));
  assign req_bit   = mask_t'(1) << req_q;
  assign waiting   = |(waiting_mask & req_bit);
  assign is_reader = |(reader_set & req_bit);
  assign is_writer = writer_active && (writer_id == req_q);

  always_comb begin
    req_ev     = rwl_pkg::EV_ERROR;
    push_wait  = 1'b0;
    push_upg   = 1'b0;
    clr_reader = 1'b0;
    release_w  = 1'b0;
    if (in_range && !waiting) begin
      case (kind_q)
        rwl_pkg::KIND_ACQ_READ: begin
          if (is_reader) begin
            req_ev = rwl_pkg::EV_HELD;
          end else if (!is_writer && !wq_full) begin
            push_wait = 1'b1;
            req_ev    = rwl_pkg::EV_QUEUED;
          end
        end
        rwl_pkg::KIND_ACQ_WRITE: begin
          if (is_writer) begin
            req_ev = rwl_pkg::EV_HELD;
          end else if (is_reader) begin
            if (!uq_full) begin
              push_upg = 1'b1;
              req_ev   = rwl_pkg::EV_QUEUED;
            end
          end else if (!wq_full) begin
            push_wait = 1'b1;
            req_ev    = rwl_pkg::EV_QUEUED;
          end
        end
        rwl_pkg::KIND_REL_READ: begin
          if (is_reader) begin
            clr_reader = 1'b1;
            req_ev     = rwl_pkg::EV_RELEASED;
          end
        end
        default: begin
          if (is_writer) begin
            release_w = 1'b1;
            req_ev    = rwl_pkg::EV_RELEASED;
          end
        end
      endcase
    end
  end

  // upgrade queue has priority over the wait queue
  assign g_from_upg = (uq_cnt != '0);
  assign g_any      = g_from_upg || (wq_cnt != '0);
  assign g_id       = g_from_upg ? uq_data : wq_data[rwl_pkg::ID_W-1:0];
  assign g_write    = g_from_upg || wq_data[EW-1];
  assign g_bit      = mask_t'(1) << g_id;
  assign g_ok       = g_any && (g_write ? ((reader_set == '0) && !writer_active)
                                        : !writer_active);

  assign status.grant_ok  = g_ok;
  assign status.slot_free = !res_valid || res_ready;

  always_comb begin
    reader_set_next    = reader_set;
    was_reading_next   = was_reading;
    waiting_mask_next  = waiting_mask;
    writer_active_next = writer_active;
    writer_id_next     = writer_id;
    wq_head_next       = wq_head;
    wq_cnt_next        = wq_cnt;
    uq_head_next       = uq_head;
    uq_cnt_next        = uq_cnt;
    if (cmd.apply_req) begin
      if (push_wait) begin
        wq_cnt_next       = wq_cnt + CW'(1);
        waiting_mask_next = waiting_mask | req_bit;
      end
      if (push_upg) begin
        uq_cnt_next       = uq_cnt + CW'(1);
        reader_set_next   = reader_set & ~req_bit;
        was_reading_next  = was_reading | req_bit;
        waiting_mask_next = waiting_mask | req_bit;
      end
      if (clr_reader) begin
        reader_set_next = reader_set & ~req_bit;
      end
      if (release_w) begin
        writer_active_next = 1'b0;
        if (|(was_reading & req_bit)) begin
          was_reading_next = was_reading & ~req_bit;
          reader_set_next  = reader_set | req_bit;
        end
      end
    end else if (cmd.apply_grant) begin
      waiting_mask_next = waiting_mask & ~g_bit;
      if (g_write) begin
        writer_active_next = 1'b1;
        writer_id_next     = g_id;
      end else begin
        reader_set_next = reader_set | g_bit;
      end
      if (g_from_upg) begin
        uq_cnt_next  = uq_cnt - CW'(1);
        uq_head_next = (uq_head == PW'(REQUESTERS - 1)) ? '0 : uq_head + PW'(1);
      end else begin
        wq_cnt_next  = wq_cnt - CW'(1);
        wq_head_next = (wq_head == PW'(REQUESTERS - 1)) ? '0 : wq_head + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reader_set    <= '0;
      was_reading   <= '0;
      waiting_mask  <= '0;
      writer_active <= 1'b0;
      writer_id     <= '0;
      wq_head       <= '0;
      wq_cnt        <= '0;
      uq_head       <= '0;
      uq_cnt        <= '0;
      res_valid     <= 1'b0;
    end else begin
      reader_set    <= reader_set_next;
      was_reading   <= was_reading_next;
      waiting_mask  <= waiting_mask_next;
      writer_active <= writer_active_next;
      writer_id     <= writer_id_next;
      wq_head       <= wq_head_next;
      wq_cnt        <= wq_cnt_next;
      uq_head       <= uq_head_next;
      uq_cnt        <= uq_cnt_next;
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_q <= kind;
      req_q  <= requester;
    end
    if (cmd.apply_req) begin
      pend_ev  <= req_ev;
      pend_who <= req_q;
    end else if (cmd.apply_grant) begin
      pend_ev  <= g_write ? rwl_pkg::EV_WRITE_GRANT : rwl_pkg::EV_READ_GRANT;
      pend_who <= g_id;
    end
    if (cmd.emit) begin
      res_event <= pend_ev;
      res_who   <= pend_who;
      res_last  <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_req && push_wait) begin
      wait_mem[wq_tail] <= {(kind_q == rwl_pkg::KIND_ACQ_WRITE), req_q};
    end
    if (cmd.apply_req && push_upg) begin
      upg_mem[uq_tail] <= req_q;
    end
    if (cmd.read_heads) begin
      wq_data <= wait_mem[wq_head];
      uq_data <= upg_mem[uq_head];
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(writer_active && (reader_set != '0)))
    else $error("writer and readers hold the lock together");

  a_wait_count: assert property (@(posedge clk) disable iff (rst)
    $countones(waiting_mask) == (32'(wq_cnt) + 32'(uq_cnt)))
    else $error("waiting mask disagrees with queue occupancy");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(wq_cnt) <= 32'(REQUESTERS)) && (32'(uq_cnt) <= 32'(REQUESTERS)))
    else $error("queue count beyond depth");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.apply_grant |-> g_ok)
    else $error("grant applied while head cannot be served");

endmodule

`default_nettype wire

### tb/sv/tb_reader_writer_lock_arbiter_top.sv
`timescale 1ns / 1ps
// Testbench for reader_writer_lock_arbiter_top: a directed lock sequence, then random traffic,
// every word checked against the arbiter predictor or a fixed answer, random idles on both sides.
// Depends on rwl_pkg, rwl_req_if, rwl_res_if and the arbiter RTL.
module tb_reader_writer_lock_arbiter_top;

  localparam int NUM_REQ        = rwl_pkg::REQUESTERS_DEF;
  localparam int TOTAL_REQUESTS = 220;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DIRECTED_ROWS  = 25;

  typedef logic [rwl_pkg::KIND_W-1:0]  kind_t;
  typedef logic [rwl_pkg::ID_W-1:0]    id_t;
  typedef logic [rwl_pkg::EVENT_W-1:0] ev_t;

  typedef struct packed {
    ev_t  ev;
    id_t  who;
    logic last;
  } lock_word_t;

  // ev is the typed answer, used only where fixed is set
  typedef struct packed {
    kind_t kind;
    id_t   id;
    logic  fixed;
    ev_t   ev;
  } plan_row_t;

  logic clk;
  logic rst;

  rwl_req_if req_ch();
  rwl_res_if res_ch();

  reader_writer_lock_arbiter_top u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  logic [NUM_REQ-1:0]      held_readers;
  logic [NUM_REQ-1:0]      former_readers;
  logic [NUM_REQ-1:0]      queued_mask;
  logic                    writer_on;
  id_t                     writer_who;
  logic [rwl_pkg::ID_W:0]  wait_line[$];
  id_t                     upgrade_line[$];
  lock_word_t              pending_words[$];
  int                      mismatches;
  int                      sent;
  int                      cycles;
  logic                    steady;

  plan_row_t plan [DIRECTED_ROWS] = '{
    '{rwl_pkg::KIND_REL_READ,  4'd0,  1'b1, rwl_pkg::EV_ERROR},
    '{rwl_pkg::KIND_REL_WRITE, 4'd15, 1'b1, rwl_pkg::EV_ERROR},
    '{rwl_pkg::KIND_ACQ_READ,  4'd0,  1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_ACQ_READ,  4'd0,  1'b1, rwl_pkg::EV_HELD},
    '{rwl_pkg::KIND_ACQ_READ,  4'd15, 1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_ACQ_WRITE, 4'd5,  1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_ACQ_READ,  4'd5,  1'b1, rwl_pkg::EV_ERROR},
    '{rwl_pkg::KIND_ACQ_READ,  4'd7,  1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_ACQ_WRITE, 4'd0,  1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_REL_READ,  4'd15, 1'b0, rwl_pkg::EV_RELEASED},
    '{rwl_pkg::KIND_ACQ_WRITE, 4'd0,  1'b1, rwl_pkg::EV_HELD},
    '{rwl_pkg::KIND_ACQ_READ,  4'd0,  1'b1, rwl_pkg::EV_ERROR},
    '{rwl_pkg::KIND_REL_READ,  4'd3,  1'b1, rwl_pkg::EV_ERROR},
    '{rwl_pkg::KIND_REL_WRITE, 4'd3,  1'b1, rwl_pkg::EV_ERROR},
    '{rwl_pkg::KIND_REL_WRITE, 4'd0,  1'b0, rwl_pkg::EV_RELEASED},
    '{rwl_pkg::KIND_ACQ_WRITE, 4'd0,  1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_REL_WRITE, 4'd0,  1'b0, rwl_pkg::EV_RELEASED},
    '{rwl_pkg::KIND_REL_READ,  4'd0,  1'b0, rwl_pkg::EV_RELEASED},
    '{rwl_pkg::KIND_ACQ_READ,  4'd10, 1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_ACQ_WRITE, 4'd11, 1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_ACQ_READ,  4'd12, 1'b0, rwl_pkg::EV_QUEUED},
    '{rwl_pkg::KIND_REL_WRITE, 4'd5,  1'b0, rwl_pkg::EV_RELEASED},
    '{rwl_pkg::KIND_REL_READ,  4'd7,  1'b0, rwl_pkg::EV_RELEASED},
    '{rwl_pkg::KIND_REL_READ,  4'd10, 1'b0, rwl_pkg::EV_RELEASED},
    '{rwl_pkg::KIND_REL_WRITE, 4'd11, 1'b0, rwl_pkg::EV_RELEASED}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Answer word, then grants walked from the upgrade queue first, else the wait queue.
  task automatic arbitrate_request(input kind_t kind, input id_t id, ref lock_word_t words[$]);
    ev_t                    ev;
    logic                   own_write;
    logic [rwl_pkg::ID_W:0] head;
    id_t                    gid;
    lock_word_t             tail;
    ev = rwl_pkg::EV_ERROR;
    own_write = writer_on && writer_who == id;
    if (int'(id) < NUM_REQ && !queued_mask[id]) begin
      case (kind)
        rwl_pkg::KIND_ACQ_READ: begin
          if (held_readers[id]) begin
            ev = rwl_pkg::EV_HELD;
          end else if (!own_write && wait_line.size() < NUM_REQ) begin
            wait_line.push_back({1'b0, id});
            queued_mask[id] = 1'b1;
            ev = rwl_pkg::EV_QUEUED;
          end
        end
        rwl_pkg::KIND_ACQ_WRITE: begin
          if (own_write) begin
            ev = rwl_pkg::EV_HELD;
          end else if (held_readers[id]) begin
            if (upgrade_line.size() < NUM_REQ) begin
              upgrade_line.push_back(id);
              held_readers[id] = 1'b0;
              former_readers[id] = 1'b1;
              queued_mask[id] = 1'b1;
              ev = rwl_pkg::EV_QUEUED;
            end
          end else if (wait_line.size() < NUM_REQ) begin
            wait_line.push_back({1'b1, id});
            queued_mask[id] = 1'b1;
            ev = rwl_pkg::EV_QUEUED;
          end
        end
        rwl_pkg::KIND_REL_READ: begin
          if (held_readers[id]) begin
            held_readers[id] = 1'b0;
            ev = rwl_pkg::EV_RELEASED;
          end
        end
        default: begin
          if (own_write) begin
            writer_on = 1'b0;
            if (former_readers[id]) begin
              former_readers[id] = 1'b0;
              held_readers[id] = 1'b1;
            end
            ev = rwl_pkg::EV_RELEASED;
          end
        end
      endcase
    end
    words.push_back('{ev, id, 1'b0});
    forever begin
      if (upgrade_line.size() != 0) begin
        if (held_readers != '0 || writer_on) break;
        gid = upgrade_line.pop_front();
        queued_mask[gid] = 1'b0;
        writer_on = 1'b1;
        writer_who = gid;
        words.push_back('{rwl_pkg::EV_WRITE_GRANT, gid, 1'b0});
      end else if (wait_line.size() != 0) begin
        head = wait_line[0];
        gid = head[rwl_pkg::ID_W-1:0];
        if (head[rwl_pkg::ID_W]) begin
          if (held_readers != '0 || writer_on) break;
          writer_on = 1'b1;
          writer_who = gid;
          words.push_back('{rwl_pkg::EV_WRITE_GRANT, gid, 1'b0});
        end else begin
          if (writer_on) break;
          held_readers[gid] = 1'b1;
          words.push_back('{rwl_pkg::EV_READ_GRANT, gid, 1'b0});
        end
        void'(wait_line.pop_front());
        queued_mask[gid] = 1'b0;
      end else begin
        break;
      end
    end
    tail = words.pop_back();
    tail.last = 1'b1;
    words.push_back(tail);
  endtask

  task automatic send_request(input kind_t kind, input id_t id, input logic fixed,
                              input ev_t fixed_ev);
    lock_word_t words[$];
    int         gap;
    if ($urandom_range(0, 19) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.requester <= id;
    do @(posedge clk); while (!req_ch.ready);
    arbitrate_request(kind, id, words);
    if (fixed) begin
      pending_words.push_back('{fixed_ev, id, 1'b1});
    end else begin
      foreach (words[i]) pending_words.push_back(words[i]);
    end
    sent++;
  endtask

  // Mostly legal lock usage with random ids; the rest is raw noise.
  task automatic send_traffic_request();
    kind_t kind;
    id_t   id;
    int    pct;
    id = id_t'($urandom_range(0, NUM_REQ - 1));
    if ($urandom_range(0, 99) < 25) begin
      kind = kind_t'($urandom_range(0, 3));
    end else begin
      for (int k = 0; k < NUM_REQ && queued_mask[id]; k++) id = id + id_t'(1);
      pct = $urandom_range(0, 99);
      if (writer_on && writer_who == id)
        kind = (pct < 70) ? rwl_pkg::KIND_REL_WRITE :
               (pct < 85) ? rwl_pkg::KIND_ACQ_WRITE : rwl_pkg::KIND_ACQ_READ;
      else if (held_readers[id])
        kind = (pct < 55) ? rwl_pkg::KIND_REL_READ :
               (pct < 85) ? rwl_pkg::KIND_ACQ_WRITE : rwl_pkg::KIND_ACQ_READ;
      else
        kind = (pct < 65) ? rwl_pkg::KIND_ACQ_READ : rwl_pkg::KIND_ACQ_WRITE;
    end
    send_request(kind, id, 1'b0, rwl_pkg::EV_ERROR);
  endtask

  // Queue a read from every idle requester behind the writer, then drop the write lock.
  task automatic send_read_burst();
    id_t holder;
    holder = writer_who;
    for (int i = 0; i < NUM_REQ; i++) begin
      if (!queued_mask[i] && !held_readers[i] && !(writer_on && writer_who == id_t'(i)))
        send_request(rwl_pkg::KIND_ACQ_READ, id_t'(i), 1'b0, rwl_pkg::EV_ERROR);
    end
    send_request(rwl_pkg::KIND_REL_WRITE, holder, 1'b0, rwl_pkg::EV_ERROR);
  endtask

  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= rwl_pkg::KIND_ACQ_READ;
    req_ch.requester <= '0;
    held_readers   = '0;
    former_readers = '0;
    queued_mask    = '0;
    writer_on      = 1'b0;
    writer_who     = '0;
    mismatches     = 0;
    sent           = 0;
    cycles         = 0;
    steady         = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send_request(plan[i].kind, plan[i].id, plan[i].fixed, plan[i].ev);
    while (sent < TOTAL_REQUESTS) begin
      if (writer_on && $urandom_range(0, 24) == 0) send_read_burst();
      else send_traffic_request();
    end
    req_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_sink
    lock_word_t got;
    lock_word_t want;
    int         stall;
    logic       calm;
    calm = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got = '{res_ch.event_res, res_ch.who, res_ch.last};
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word event=%0d who=%0d last=%0d",
                 $time, got.ev, got.who, got.last);
      end else begin
        want = pending_words.pop_front();
        if (got.ev !== want.ev) begin
          mismatches++;
          $display("%0t: event_res expected %0d got %0d", $time, want.ev, got.ev);
        end
        if (got.who !== want.who) begin
          mismatches++;
          $display("%0t: who expected %0d got %0d", $time, want.who, got.who);
        end
        if (got.last !== want.last) begin
          mismatches++;
          $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
        end
      end
    end
  end

endmodule

### filelist.f
design/rwl_pkg.sv
design/rwl_req_if.sv
design/rwl_res_if.sv
design/rwl_ctrl.sv
design/rwl_dp.sv
design/reader_writer_lock_arbiter_top.sv
tb/sv/tb_reader_writer_lock_arbiter_top.sv
